>>> hdl/dsm_pkg.sv
// Shared types and constants for the downstream segment matcher.
// Standalone package; used by the core and its checker.
`timescale 1ns / 1ps

package dsm_pkg;

  // Default table depth
  localparam int unsigned MaxSegments = 256;

  // Item opcodes carried on the action field
  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_FOUND    = 3'd0,
    ST_BOUNDARY = 3'd1,
    ST_BADINDEX = 3'd2,
    ST_STORED   = 3'd3,
    ST_FULL     = 3'd4,
    ST_CLEARED  = 3'd5
  } status_e;

  // One row of the id/from-node memory
  typedef struct packed {
    logic [31:0] seg_id;
    logic [31:0] src_node;
  } seg_entry_t;

endpackage

>>> hdl/downstream_segment_matcher_core.sv
// Downstream segment matcher: segment table in two synchronous RAMs plus scan sequencer.
// Depends on dsm_pkg.
`timescale 1ns / 1ps

// An item is taken when start_i is high and busy_o is low; every item gives exactly
// one result word, shown for one cycle with done_o high, and the receiver must take
// it then. Append, clear and rejected items answer in the cycle after they are taken
// and never raise busy_o. A valid query reads the queried to-node and then walks the
// table from position zero, one entry per cycle through the single read port of the
// id/from-node RAM; it answers with the first row whose from-node equals that
// to-node, and its position, or with the boundary code when no segment starts there.
// busy_o is high for the walk, blocking any append while the table is read. The table
// needs no clearing pass: the entry count alone marks live rows. The boundary code is
// written via cfg_* (always ready) by the user only while idle, unenforced by the block.
module downstream_segment_matcher_core #(
  parameter int unsigned MAX_SEGMENTS = dsm_pkg::MaxSegments
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item channel
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] segment_id_i,
  input  logic [31:0] start_node_i,
  input  logic [31:0] end_node_i,
  input  logic [7:0]  query_index_i,
  // result channel
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [31:0] downstream_id_o,
  output logic [7:0]  match_index_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned QW = (CW > 8) ? CW : 8;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        scan_q, scan_d;
  logic [31:0]          boundary_q;

  logic                 done_q, done_d;
  dsm_pkg::status_e     status_q, status_d;
  logic [31:0]          dsid_q, dsid_d;
  logic [7:0]           midx_q, midx_d;

  // table storage
  dsm_pkg::seg_entry_t  pair_mem [MAX_SEGMENTS];
  logic [31:0]          to_mem   [MAX_SEGMENTS];
  dsm_pkg::seg_entry_t  pair_rd_q;
  logic [31:0]          target_q;

  logic                 accept;
  logic                 wr_en;
  logic                 pair_rd_en;
  logic                 to_rd_en;
  logic [AW-1:0]        pair_rd_addr;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        q_addr;
  logic [CW-1:0]        scan_next;
  logic                 q_in_range;

  assign accept      = start_i && (state_q == S_IDLE);
  assign wr_addr     = count_q[AW-1:0];
  assign q_addr      = AW'(QW'(query_index_i));
  assign q_in_range  = QW'(query_index_i) < QW'(count_q);
  assign scan_next   = CW'(scan_q) + CW'(1);

  // Decode the item, sequence the scan and form the result word
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    done_d       = 1'b0;
    status_d     = status_q;
    dsid_d       = dsid_q;
    midx_d       = midx_q;
    wr_en        = 1'b0;
    to_rd_en     = 1'b0;
    pair_rd_en   = 1'b0;
    pair_rd_addr = scan_next[AW-1:0];
    unique case (state_q)
      S_IDLE: begin
        pair_rd_addr = '0;
        if (accept) begin
          done_d   = 1'b1;
          status_d = dsm_pkg::ST_BADINDEX;
          dsid_d   = '0;
          midx_d   = '0;
          unique case (action_i)
            dsm_pkg::ACT_APPEND: begin
              if (count_q == CW'(MAX_SEGMENTS)) begin
                status_d = dsm_pkg::ST_FULL;
              end else begin
                status_d = dsm_pkg::ST_STORED;
                wr_en    = 1'b1;
                count_d  = count_q + CW'(1);
              end
            end
            dsm_pkg::ACT_CLEAR: begin
              status_d = dsm_pkg::ST_CLEARED;
              count_d  = '0;
            end
            dsm_pkg::ACT_QUERY: begin
              if (q_in_range) begin
                // hold the answer back until the walk ends
                done_d     = 1'b0;
                to_rd_en   = 1'b1;
                pair_rd_en = 1'b1;
                scan_d     = '0;
                state_d    = S_SCAN;
              end
            end
            default: begin
              status_d = dsm_pkg::ST_BADINDEX;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pair_rd_q.src_node == target_q) begin
          done_d   = 1'b1;
          status_d = dsm_pkg::ST_FOUND;
          dsid_d   = pair_rd_q.seg_id;
          midx_d   = 8'(scan_q);
          state_d  = S_IDLE;
        end else if (scan_next == count_q) begin
          done_d   = 1'b1;
          status_d = dsm_pkg::ST_BOUNDARY;
          dsid_d   = boundary_q;
          midx_d   = '0;
          state_d  = S_IDLE;
        end else begin
          // advance to the next row
          pair_rd_en = 1'b1;
          scan_d     = scan_next[AW-1:0];
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      count_q    <= '0;
      done_q     <= 1'b0;
      boundary_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_valid_i) begin
        boundary_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    scan_q   <= scan_d;
    status_q <= status_d;
    dsid_q   <= dsid_d;
    midx_q   <= midx_d;
  end

  // Id/from-node RAM: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[wr_addr] <= '{seg_id: segment_id_i, src_node: start_node_i};
    end
    if (pair_rd_en) begin
      pair_rd_q <= pair_mem[pair_rd_addr];
    end
  end

  // To-node RAM: target read once per query, then held for the walk
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      to_mem[wr_addr] <= end_node_i;
    end
    if (to_rd_en) begin
      target_q <= to_mem[q_addr];
    end
  end

  assign busy_o          = (state_q == S_SCAN);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign downstream_id_o = dsid_q;
  assign match_index_o   = midx_q;
  assign cfg_ready_o     = 1'b1;

endmodule

>>> hdl/dsm_checker.sv
// Port-level checker for the downstream segment matcher core, with its bind.
// Depends on dsm_pkg and downstream_segment_matcher_core.
`timescale 1ns / 1ps

module dsm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic [1:0]  action_i,
  input logic        done_o,
  input logic [2:0]  status_o,
  input logic [31:0] downstream_id_o,
  input logic [7:0]  match_index_o
);

  logic take;
  assign take = start_i && !busy_o;

  // Non-query words answer in the next cycle without a walk
  a_quick_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (action_i != dsm_pkg::ACT_QUERY) |=> done_o && !busy_o)
    else $error("non-query word did not answer next cycle");

  // A query either walks or is rejected at once
  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (action_i == dsm_pkg::ACT_QUERY) |=> (busy_o != done_o))
    else $error("query neither walked nor answered");

  // End of a walk comes with its result word
  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("walk ended without a result");

  // Only matches and boundary answers carry an id; only matches carry a position
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != dsm_pkg::ST_FOUND) |->
      (match_index_o == 8'd0) &&
      ((status_o == dsm_pkg::ST_BOUNDARY) || (downstream_id_o == 32'd0)))
    else $error("non-match result carries stray fields");

endmodule

bind downstream_segment_matcher_core dsm_checker u_dsm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start_i),
  .busy_o          (busy_o),
  .action_i        (action_i),
  .done_o          (done_o),
  .status_o        (status_o),
  .downstream_id_o (downstream_id_o),
  .match_index_o   (match_index_o)
);
